### hw/rtl/lfp_pkg.sv
// Shared types and constants for the lidar frame parser.
`timescale 1ns / 1ps

package lfp_pkg;

  localparam int ByteW   = 8;
  localparam int DistW   = 16;
  localparam int StrW    = 16;
  localparam int QualW   = 8;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 1;
  localparam int PosW    = 3;

  localparam logic [ByteW-1:0]   SyncByte   = 8'h59;
  // Two sync bytes already summed, mod 256
  localparam logic [ByteW-1:0]   SumSeed    = 8'hB2;
  localparam logic [PosW-1:0]    PosLast    = 3'd5;
  localparam logic [DistW-1:0]   MinDistRst = 16'd20;
  localparam logic [StrW-1:0]    MaxStrRst  = 16'd300;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMinDist = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxStr  = 1'b1;

  // Payload byte slots
  localparam logic [PosW-1:0] PosDistLo = 3'd0;
  localparam logic [PosW-1:0] PosDistHi = 3'd1;
  localparam logic [PosW-1:0] PosStrLo  = 3'd2;
  localparam logic [PosW-1:0] PosStrHi  = 3'd3;
  localparam logic [PosW-1:0] PosQual   = 3'd5;

  typedef enum logic [1:0] {
    PH_SYNC1   = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } lfp_phase_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [StrW-1:0]  strength;
    logic [QualW-1:0] quality;
    logic             valid_res;
    logic [DistW-1:0] altitude;
  } lfp_res_t;

endpackage

### hw/rtl/lfp_in_if.sv
// Byte input channel interface.
`timescale 1ns / 1ps

interface lfp_in_if;
  logic                    valid;
  logic                    ready;
  logic [lfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/lfp_out_if.sv
// Frame result channel interface.
`timescale 1ns / 1ps

interface lfp_out_if;
  logic                      valid;
  logic                      ready;
  logic [lfp_pkg::DistW-1:0] distance;
  logic [lfp_pkg::StrW-1:0]  strength;
  logic [lfp_pkg::QualW-1:0] quality;
  logic                      valid_res;
  logic [lfp_pkg::DistW-1:0] altitude;

  modport source (output valid, output distance, output strength, output quality,
                  output valid_res, output altitude, input ready);
  modport sink   (input valid, input distance, input strength, input quality,
                  input valid_res, input altitude, output ready);
endinterface

### hw/rtl/lfp_parser.sv
// Frame sync, payload capture, running checksum and held altitude.
`timescale 1ns / 1ps

module lfp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      beat,
  input  logic [lfp_pkg::ByteW-1:0] rx_byte,
  input  logic [lfp_pkg::CfgW-1:0]  min_distance,
  input  logic [lfp_pkg::CfgW-1:0]  max_strength,
  output logic                      in_check,
  output logic                      res_vld,
  output lfp_pkg::lfp_res_t         res
);
  import lfp_pkg::*;

  lfp_phase_t       phase_r, phase_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] dist_lo_r, dist_hi_r, str_lo_r, str_hi_r, qual_r;
  logic [DistW-1:0] alt_r, alt_nxt;
  logic [DistW-1:0] frame_dist;
  logic [StrW-1:0]  str;
  logic             ok;
  logic             sum_hit;

  assign frame_dist = {dist_hi_r, dist_lo_r};
  assign str     = {str_hi_r, str_lo_r};
  assign ok      = !((frame_dist < min_distance) || (str > max_strength));
  assign sum_hit = (rx_byte == sum_r);
  assign in_check = (phase_r == PH_CHECK);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    alt_nxt   = alt_r;
    res_vld   = 1'b0;
    if (beat) begin
      unique case (phase_r)
        PH_SYNC1: begin
          if (rx_byte == SyncByte) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          // A bad second byte restarts the hunt; it is not a new first sync
          phase_nxt = (rx_byte == SyncByte) ? PH_PAYLOAD : PH_SYNC1;
          sum_nxt   = SumSeed;
          pos_nxt   = '0;
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + rx_byte;
          pos_nxt = pos_r + PosW'(1);
          if (pos_r == PosLast) phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          phase_nxt = PH_SYNC1;
          if (sum_hit) begin
            res_vld = 1'b1;
            if (ok) alt_nxt = frame_dist;
          end
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    res.distance  = frame_dist;
    res.strength  = str;
    res.quality   = qual_r;
    res.valid_res = ok;
    res.altitude  = alt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      pos_r   <= '0;
      alt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      alt_r   <= alt_nxt;
    end
  end

  // Payload capture; the unused payload byte goes only into the sum
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (beat && phase_r == PH_PAYLOAD) begin
      unique case (pos_r)
        PosDistLo: dist_lo_r <= rx_byte;
        PosDistHi: dist_hi_r <= rx_byte;
        PosStrLo:  str_lo_r  <= rx_byte;
        PosStrHi:  str_hi_r  <= rx_byte;
        PosQual:   qual_r    <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/lidar_frame_parser.sv
// Top level of the lidar frame parser: config registers and result register.
`timescale 1ns / 1ps
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-------------
//  in_bus   | in  | rx_byte[7:0]                                   | valid/ready
//  out_bus  | out | distance, strength, quality, valid_res, altitude | valid/ready
//  cfg_*    | in  | cfg_idx (0 min_distance, 1 max_strength), cfg_wdata | cfg_we
//
// One byte is taken per cycle; input stalls only when a checksum byte
// arrives while an earlier result still waits downstream. The parser
// state, running checksum and payload bytes update on each beat; a frame
// result is loaded into the output register in the same cycle its checksum
// byte arrives and shows the next cycle. Synchronous reset clears the hunt
// state, held altitude, the output valid and loads the default limits.

module lidar_frame_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  lfp_in_if.sink                      in_bus,
  lfp_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [lfp_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [lfp_pkg::CfgW-1:0]    cfg_wdata
);
  import lfp_pkg::*;

  logic [CfgW-1:0] min_dist_r, max_str_r;
  logic            in_beat;
  logic            in_check;
  logic            res_vld;
  lfp_res_t        res;
  lfp_res_t        out_r;
  logic            out_v_r;
  logic            slot_free;

  // Output slot frees when empty or drained this cycle
  assign slot_free    = !out_v_r || out_bus.ready;
  // Only a checksum byte can produce a result; other bytes never wait
  assign in_bus.ready = slot_free || !in_check;
  assign in_beat      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MinDistRst;
      max_str_r  <= MaxStrRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegMinDist: min_dist_r <= cfg_wdata;
        RegMaxStr:  max_str_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lfp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (in_beat),
    .rx_byte      (in_bus.rx_byte),
    .min_distance (min_dist_r),
    .max_strength (max_str_r),
    .in_check     (in_check),
    .res_vld      (res_vld),
    .res          (res)
  );

  // Result register: load a new frame, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_vld) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) out_r <= res;
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.distance  = out_r.distance;
  assign out_bus.strength  = out_r.strength;
  assign out_bus.quality   = out_r.quality;
  assign out_bus.valid_res = out_r.valid_res;
  assign out_bus.altitude  = out_r.altitude;

`ifndef NO_ASSERTIONS
  // A new result never lands on a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_bus.ready) |-> !res_vld)
    else $error("result overwrote a waiting beat");

  // Results only come from accepted bytes
  a_res_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> in_beat)
    else $error("result without input beat");

  // A passing frame carries its own distance as altitude
  a_alt_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.valid_res) |-> (out_r.altitude == out_r.distance))
    else $error("altitude does not follow valid distance");

  // Reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r)
    else $error("result valid after reset");
`endif

endmodule
